// File: sv/rgbk_pkg.sv
// Shared types, constants and helpers of the RGB 3x3 kernel filter.
`default_nettype none
package rgbk_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int COEF_FRAC_BITS = 16;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int DIM_W   = 11;
   localparam int CMP_W   = 14;
   localparam int OUT_W   = 10;
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int TSUM_W  = 13;
   localparam int SCALE_W = COEF_FRAC_BITS + 1;
   localparam int PROD_W  = TSUM_W + SCALE_W + 1;
   localparam int CSR_W   = 3;

   localparam longint BOX_COEF =
      ((64'd111111 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000;

   typedef enum logic [2:0] {
      MODE_GAUSS     = 3'd0,
      MODE_BOX       = 3'd1,
      MODE_EDGE      = 3'd2,
      MODE_LAPLACIAN = 3'd3,
      MODE_EMBOSS    = 3'd4,
      MODE_MOTION    = 3'd5,
      MODE_SHARPEN   = 3'd6
   } mode_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_FILTER_MODE   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_IMAGE_WIDTH   = 3'd2,
      CSR_SEL_ROW_START = 3'd3,
      CSR_SEL_ROW_END   = 3'd4,
      CSR_SEL_COL_START = 3'd5,
      CSR_SEL_COL_END   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] image_height;
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] sel_row_start;
      logic [DIM_W-1:0] sel_row_end;
      logic [DIM_W-1:0] sel_col_start;
      logic [DIM_W-1:0] sel_col_end;
   } geom_type;

   typedef struct packed {
      logic [OUT_W-1:0] row;
      logic [OUT_W-1:0] col;
      logic [COL_W-1:0] col_idx;
      logic [OUT_W-1:0] ctr_row;
      logic [OUT_W-1:0] ctr_col;
      logic             cen;
      logic             sel;
      logic             bord;
   } pos_type;

   typedef struct packed {
      logic [OUT_W-1:0] ctr_row;
      logic [OUT_W-1:0] ctr_col;
      logic [PIX_W-1:0] ctr_px;
      logic [OUT_W-1:0] bord_row;
      logic [OUT_W-1:0] bord_col;
      logic [PIX_W-1:0] bord_px;
      logic             cen;
      logic             bord;
   } res_type;

   // Q-format weight that turns an integer tap sum into the exact sum.
   function automatic logic [SCALE_W-1:0] kernel_scale(input logic [2:0] mode);
      logic [SCALE_W-1:0] s;
      case (mode_type'(mode))
         MODE_GAUSS: s = SCALE_W'(1) << (COEF_FRAC_BITS - 4);
         MODE_BOX:   s = SCALE_W'(BOX_COEF);
         default:    s = SCALE_W'(1) << COEF_FRAC_BITS;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// File: sv/rgbk_ram.sv
// Single-port-write, registered-read RAM used for the line stores.
`default_nettype none
module rgbk_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/rgbk_position.sv
// Row/column counters and the per-pixel position flags.
`default_nettype none
module rgbk_position
   import rgbk_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire geom_type geom,
   output pos_type       pos
);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic [CMP_W-1:0] h, w, r, c, cr, cc, c_nx, r_nx;
   logic             outside;

   always_comb begin
      if (geom.image_height == '0) begin
         h = CMP_W'(1);
      end else if (CMP_W'(geom.image_height) > CMP_W'(MAX_HEIGHT)) begin
         h = CMP_W'(MAX_HEIGHT);
      end else begin
         h = CMP_W'(geom.image_height);
      end
      if (geom.image_width == '0) begin
         w = CMP_W'(1);
      end else if (CMP_W'(geom.image_width) > CMP_W'(MAX_WIDTH)) begin
         w = CMP_W'(MAX_WIDTH);
      end else begin
         w = CMP_W'(geom.image_width);
      end

      outside = (CMP_W'(row_ff) >= h) || (CMP_W'(col_ff) >= w);
      r  = outside ? '0 : CMP_W'(row_ff);
      c  = outside ? '0 : CMP_W'(col_ff);
      cr = r - CMP_W'(1);
      cc = c - CMP_W'(1);

      pos.row     = OUT_W'(r);
      pos.col     = OUT_W'(c);
      pos.col_idx = COL_W'(c);
      pos.ctr_row = OUT_W'(cr);
      pos.ctr_col = OUT_W'(cc);
      pos.cen     = (r >= CMP_W'(2)) && (c >= CMP_W'(2));
      pos.sel     = (cr >= CMP_W'(geom.sel_row_start)) && (cr < CMP_W'(geom.sel_row_end)) &&
                    (cc >= CMP_W'(geom.sel_col_start)) && (cc < CMP_W'(geom.sel_col_end));
      pos.bord    = (r == '0) || (r == h - CMP_W'(1)) || (c == '0) || (c == w - CMP_W'(1));

      c_nx = c + CMP_W'(1);
      r_nx = r + CMP_W'(1);
      if (c_nx >= w) begin
         col_in = '0;
         row_in = (r_nx >= h) ? '0 : ROW_W'(r_nx);
      end else begin
         col_in = COL_W'(c_nx);
         row_in = ROW_W'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/rgbk_tap_sum.sv
// Integer tap sum of one color channel over the 3x3 window.
`default_nettype none
module rgbk_tap_sum
   import rgbk_pkg::*;
(
   input  wire logic [CH_W-1:0]           taps [9],
   input  wire logic [2:0]                mode,
   output logic signed [TSUM_W-1:0]       tsum
);

   logic signed [TSUM_W-1:0] p [9];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         p[i] = $signed(TSUM_W'(taps[i]));
      end
      case (mode_type'(mode))
         MODE_GAUSS:
            tsum = p[0] + (p[1] <<< 1) + p[2] + (p[3] <<< 1) + (p[4] <<< 2) +
                   (p[5] <<< 1) + p[6] + (p[7] <<< 1) + p[8];
         MODE_BOX:
            tsum = p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7] + p[8];
         MODE_EDGE:
            tsum = (p[4] <<< 3) - (p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8]);
         MODE_LAPLACIAN:
            tsum = p[1] + p[3] + (p[4] <<< 2) + p[5] + p[7];
         MODE_EMBOSS:
            tsum = p[1] - p[3] + p[5] - p[7];
         MODE_MOTION:
            tsum = p[0] + p[1] + p[2] - p[6] - p[7] - p[8];
         default:
            tsum = (p[4] <<< 2) + p[4] - p[1] - p[3] - p[5] - p[7];
      endcase
   end

endmodule
`default_nettype wire

// File: sv/rgbk_scale_clamp.sv
// Coefficient scaling, round half up and clamp to 0..255 for one channel.
`default_nettype none
module rgbk_scale_clamp
   import rgbk_pkg::*;
(
   input  wire logic signed [TSUM_W-1:0] tsum,
   input  wire logic [SCALE_W-1:0]       scale,
   output logic [CH_W-1:0]               value
);

   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] TOP  = PROD_W'((1 << CH_W) - 1);

   logic signed [PROD_W-1:0] prod, rnd, q;

   always_comb begin
      prod = PROD_W'(tsum) * PROD_W'($signed({1'b0, scale}));
      rnd  = prod + HALF;
      q    = rnd >>> COEF_FRAC_BITS;
      if (rnd < 0) begin
         value = '0;
      end else if (q > TOP) begin
         value = '1;
      end else begin
         value = CH_W'(q);
      end
   end

endmodule
`default_nettype wire

// File: sv/rgbk_emit.sv
// Result register that delivers an item's center result and then its border result, or whichever one it has.
`default_nettype none
module rgbk_emit
   import rgbk_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire res_type          in_res,
   output logic                  in_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [OUT_W-1:0]      rsp_out_row,
   output logic [OUT_W-1:0]      rsp_out_col,
   output logic [CH_W-1:0]       rsp_out_red,
   output logic [CH_W-1:0]       rsp_out_green,
   output logic [CH_W-1:0]       rsp_out_blue,
   output logic                  rsp_last_of_run
);

   res_type    hold_ff;
   logic       cen_ff, cen_in;
   logic       bord_ff, bord_in;
   logic       load;
   logic [PIX_W-1:0] px;

   assign rsp_valid       = cen_ff | bord_ff;
   assign rsp_last_of_run = ~(cen_ff & bord_ff);
   assign in_ready        = ~rsp_valid | (rsp_ready & rsp_last_of_run);
   assign load            = in_valid & in_ready;

   assign rsp_out_row   = cen_ff ? hold_ff.ctr_row : hold_ff.bord_row;
   assign rsp_out_col   = cen_ff ? hold_ff.ctr_col : hold_ff.bord_col;
   assign px            = cen_ff ? hold_ff.ctr_px : hold_ff.bord_px;
   assign rsp_out_red   = px[2*CH_W +: CH_W];
   assign rsp_out_green = px[CH_W +: CH_W];
   assign rsp_out_blue  = px[0 +: CH_W];

   always_comb begin
      cen_in  = cen_ff;
      bord_in = bord_ff;
      if (load) begin
         cen_in  = in_res.cen;
         bord_in = in_res.bord;
      end else if (rsp_valid && rsp_ready) begin
         if (cen_ff) begin
            cen_in = 1'b0;
         end else begin
            bord_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_ff  <= 1'b0;
         bord_ff <= 1'b0;
      end else begin
         cen_ff  <= cen_in;
         bord_ff <= bord_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= in_res;
      end
   end

endmodule
`default_nettype wire

// File: sv/rgb_3x3_kernel_filter_unit.sv
// Top level of the streaming RGB 3x3 kernel filter.
//
//   channel  ports        dir  carries
//   req      req_*        in   one pixel per item, raster order
//   rsp      rsp_*        out  result pixel with row, column, last_of_run
//   csr      csr_*        in   register index and write data
//
// One pixel per clock sustained while the result side is ready; an item with both a center
// and a border result holds the result register for both and stalls the pipeline meanwhile.
// From accept to result: line store read, window shift, tap sum, scale and clamp.
// Reset clears counters, window, configuration registers and pipeline valids; line stores stay
// unwritten. A stalled result side backs up through the pipeline into req_ready.
`default_nettype none
module rgb_3x3_kernel_filter_unit
   import rgbk_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CH_W-1:0]    req_red,
   input  wire logic [CH_W-1:0]    req_green,
   input  wire logic [CH_W-1:0]    req_blue,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [OUT_W-1:0]        rsp_out_row,
   output logic [OUT_W-1:0]        rsp_out_col,
   output logic [CH_W-1:0]         rsp_out_red,
   output logic [CH_W-1:0]         rsp_out_green,
   output logic [CH_W-1:0]         rsp_out_blue,
   output logic                    rsp_last_of_run,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CSR_W-1:0]   csr_index,
   input  wire logic [DIM_W-1:0]   csr_wdata
);

   // configuration
   logic [2:0] mode_ff;
   geom_type   geom_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff               <= MODE_SHARPEN;
         geom_ff.image_height  <= DIM_W'(1024);
         geom_ff.image_width   <= DIM_W'(1024);
         geom_ff.sel_row_start <= '0;
         geom_ff.sel_row_end   <= DIM_W'(1024);
         geom_ff.sel_col_start <= '0;
         geom_ff.sel_col_end   <= DIM_W'(1024);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FILTER_MODE:   mode_ff               <= csr_wdata[2:0];
            CSR_IMAGE_HEIGHT:  geom_ff.image_height  <= csr_wdata;
            CSR_IMAGE_WIDTH:   geom_ff.image_width   <= csr_wdata;
            CSR_SEL_ROW_START: geom_ff.sel_row_start <= csr_wdata;
            CSR_SEL_ROW_END:   geom_ff.sel_row_end   <= csr_wdata;
            CSR_SEL_COL_START: geom_ff.sel_col_start <= csr_wdata;
            CSR_SEL_COL_END:   geom_ff.sel_col_end   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline flow control
   logic    accept;
   logic    s1_v_ff, s1_v_in, s1_go, s1_free;
   logic    s2_v_ff, s2_v_in, s2_go, s2_free;
   logic    s3_v_ff, s3_v_in, s3_go, s3_free;
   logic    emit_ready, has_res;

   pos_type s1_pos_ff, s2_pos_ff, s3_pos_ff;
   pos_type pos_in;

   assign has_res  = s3_pos_ff.cen | s3_pos_ff.bord;
   assign s3_go    = s3_v_ff & (~has_res | emit_ready);
   assign s3_free  = ~s3_v_ff | s3_go;
   assign s2_go    = s2_v_ff & s3_free;
   assign s2_free  = ~s2_v_ff | s2_go;
   assign s1_go    = s1_v_ff & s2_free;
   assign s1_free  = ~s1_v_ff | s1_go;
   assign req_ready = s1_free;
   assign accept   = req_valid & req_ready;

   assign s1_v_in = accept | (s1_v_ff & ~s1_go);
   assign s2_v_in = s1_go | (s2_v_ff & ~s2_go);
   assign s3_v_in = s2_go | (s3_v_ff & ~s3_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   rgbk_position u_position (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .geom    (geom_ff),
      .pos     (pos_in)
   );

   // stage 1: line store read
   logic [PIX_W-1:0] px_in, s1_px_ff;
   logic [PIX_W-1:0] rd_up, rd_lo, up_eff, lo_eff;
   logic             byp_ff, byp_in;
   logic [PIX_W-1:0] byp_up_ff, byp_lo_ff;

   assign px_in  = {req_red, req_green, req_blue};
   assign byp_in = s1_go && (pos_in.col_idx == s1_pos_ff.col_idx);
   assign up_eff = byp_ff ? byp_up_ff : rd_up;
   assign lo_eff = byp_ff ? byp_lo_ff : rd_lo;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff <= pos_in;
         s1_px_ff  <= px_in;
         byp_ff    <= byp_in;
         byp_up_ff <= lo_eff;
         byp_lo_ff <= s1_px_ff;
      end
   end

   rgbk_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_store_upper (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_pos_ff.col_idx),
      .wr_data (lo_eff),
      .rd_en   (accept),
      .rd_addr (pos_in.col_idx),
      .rd_data (rd_up)
   );

   rgbk_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_store_lower (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_pos_ff.col_idx),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (pos_in.col_idx),
      .rd_data (rd_lo)
   );

   // stage 2: window
   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] s2_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_go) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= up_eff;
         win_ff[1][2] <= lo_eff;
         win_ff[2][2] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_pos_ff <= s1_pos_ff;
         s2_px_ff  <= s1_px_ff;
      end
   end

   // stage 3: tap sums, then scale and clamp into the result register
   logic signed [TSUM_W-1:0] tsum_in [3];
   logic signed [TSUM_W-1:0] s3_tsum_ff [3];
   logic [PIX_W-1:0]         s3_px_ff, s3_ctr_ff;
   logic [CH_W-1:0]          filt [3];
   logic [SCALE_W-1:0]       scale;

   assign scale = kernel_scale(mode_ff);

   for (genvar k = 0; k < 3; k++) begin : g_chan
      logic [CH_W-1:0] taps [9];
      for (genvar t = 0; t < 9; t++) begin : g_tap
         assign taps[t] = win_ff[t / 3][t % 3][(2 - k) * CH_W +: CH_W];
      end

      rgbk_tap_sum u_tap_sum (
         .taps (taps),
         .mode (mode_ff),
         .tsum (tsum_in[k])
      );

      rgbk_scale_clamp u_scale_clamp (
         .tsum  (s3_tsum_ff[k]),
         .scale (scale),
         .value (filt[k])
      );
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         s3_pos_ff <= s2_pos_ff;
         s3_px_ff  <= s2_px_ff;
         s3_ctr_ff <= win_ff[1][1];
         for (int k = 0; k < 3; k++) begin
            s3_tsum_ff[k] <= tsum_in[k];
         end
      end
   end

   res_type res;

   always_comb begin
      res.ctr_row  = s3_pos_ff.ctr_row;
      res.ctr_col  = s3_pos_ff.ctr_col;
      res.ctr_px   = s3_pos_ff.sel ? {filt[0], filt[1], filt[2]} : s3_ctr_ff;
      res.bord_row = s3_pos_ff.row;
      res.bord_col = s3_pos_ff.col;
      res.bord_px  = s3_px_ff;
      res.cen      = s3_pos_ff.cen;
      res.bord     = s3_pos_ff.bord;
   end

   rgbk_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s3_v_ff & has_res),
      .in_res          (res),
      .in_ready        (emit_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
`default_nettype wire

// File: sv/rgbk_checker.sv
// Port-level assertions for the RGB 3x3 kernel filter, bound to the top level.
`default_nettype none
module rgbk_checker
   import rgbk_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [OUT_W-1:0]   rsp_out_row,
   input wire logic [OUT_W-1:0]   rsp_out_col,
   input wire logic [CH_W-1:0]    rsp_out_red,
   input wire logic [CH_W-1:0]    rsp_out_green,
   input wire logic [CH_W-1:0]    rsp_out_blue,
   input wire logic               rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_row) &&
      $stable(rsp_out_col) && $stable(rsp_out_red) && $stable(rsp_out_green) &&
      $stable(rsp_out_blue) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("second result of an item missing");

   a_second_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
      rsp_out_row == OUT_W'($past(rsp_out_row) + OUT_W'(1)) &&
      rsp_out_col == OUT_W'($past(rsp_out_col) + OUT_W'(1)))
      else $error("border result not one row and column past the center");

endmodule

bind rgb_3x3_kernel_filter_unit rgbk_checker u_rgbk_checker (.*);
`default_nettype wire

// File: dv/tb_rgb_3x3_kernel_filter_unit.sv
// Self-checking testbench of the RGB 3x3 kernel filter: random images against a pixel predictor.
module tb_rgb_3x3_kernel_filter_unit;
   import rgbk_pkg::*;

   localparam int               IDLE_LIMIT      = 3000;
   localparam int               DRAIN_CYCLES    = 12;
   localparam int               HOLD_CYCLES     = 400;
   localparam int               SMALL_ITEMS     = 750;
   localparam logic [2:0]       MODE_SPARE      = 3'd7;
   localparam logic [2:0]       CSR_SPARE       = 3'd7;
   localparam logic [DIM_W-1:0] DIM_TOP         = '1;
   localparam longint           Q_ONE           = longint'(1) << COEF_FRAC_BITS;
   localparam longint           BOX_TAP         =
      ((longint'(111111) << COEF_FRAC_BITS) + 500000) / 1000000;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic [OUT_W-1:0] row;
      logic [OUT_W-1:0] col;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic             last;
   } out_pixel_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [CH_W-1:0]    req_red = '0;
   logic [CH_W-1:0]    req_green = '0;
   logic [CH_W-1:0]    req_blue = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [OUT_W-1:0]   rsp_out_row;
   logic [OUT_W-1:0]   rsp_out_col;
   logic [CH_W-1:0]    rsp_out_red;
   logic [CH_W-1:0]    rsp_out_green;
   logic [CH_W-1:0]    rsp_out_blue;
   logic               rsp_last_of_run;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_index = '0;
   logic [DIM_W-1:0]   csr_wdata = '0;

   rgb_3x3_kernel_filter_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   pixel_type        upper_line [MAX_WIDTH];
   pixel_type        lower_line [MAX_WIDTH];
   pixel_type        win [3][3] = '{default: '0};
   int unsigned      row_pos = 0;
   int unsigned      col_pos = 0;
   logic [2:0]       cfg_mode = MODE_SHARPEN;
   logic [DIM_W-1:0] cfg_height = DIM_W'(1024);
   logic [DIM_W-1:0] cfg_width = DIM_W'(1024);
   logic [DIM_W-1:0] cfg_row_lo = '0;
   logic [DIM_W-1:0] cfg_row_hi = DIM_W'(1024);
   logic [DIM_W-1:0] cfg_col_lo = '0;
   logic [DIM_W-1:0] cfg_col_hi = DIM_W'(1024);

   pixel_type        pixels_to_send [$];
   out_pixel_type    out_pixels_due [$];
   out_pixel_type    seen_due;
   int unsigned      pixels_queued = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      idle_cycles = 0;
   bit               pix_offered = 1'b0;
   bit               pix_taken = 1'b0;
   int unsigned      pix_gap = 0;
   bit               feed_gaps_on = 1'b0;
   bit               drain_stalls_on = 1'b0;
   bit               sink_hold_request = 1'b0;
   int unsigned      sink_hold = 0;
   int unsigned      sink_stall = 0;

   function automatic int unsigned clip_dim(logic [DIM_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
   endfunction

   function automatic longint tap_coef(int k);
      case (cfg_mode)
         MODE_GAUSS:     return (k == 4) ? Q_ONE / 4 : (k % 2 == 1) ? Q_ONE / 8 : Q_ONE / 16;
         MODE_BOX:       return BOX_TAP;
         MODE_EDGE:      return (k == 4) ? 8 * Q_ONE : -Q_ONE;
         MODE_LAPLACIAN: return (k == 4) ? 4 * Q_ONE : (k % 2 == 1) ? Q_ONE : 0;
         MODE_EMBOSS:    return (k == 1 || k == 5) ? Q_ONE : (k == 3 || k == 7) ? -Q_ONE : 0;
         MODE_MOTION:    return (k < 3) ? Q_ONE : (k > 5) ? -Q_ONE : 0;
         default:        return (k == 4) ? 5 * Q_ONE : (k % 2 == 1) ? -Q_ONE : 0;
      endcase
   endfunction

   function automatic logic [CH_W-1:0] filtered_channel(int lsb);
      longint acc;
      acc = longint'(1) << (COEF_FRAC_BITS - 1);
      for (int k = 0; k < 9; k++)
         acc += tap_coef(k) * longint'({1'b0, win[k / 3][k % 3][lsb +: CH_W]});
      if (acc < 0) return '0;
      acc = acc >>> COEF_FRAC_BITS;
      return (acc > 255) ? CH_W'(255) : CH_W'(acc);
   endfunction

   function automatic out_pixel_type as_result(int unsigned r, int unsigned c, pixel_type px);
      out_pixel_type o;
      o.row   = OUT_W'(r);
      o.col   = OUT_W'(c);
      o.red   = px[23:16];
      o.green = px[15:8];
      o.blue  = px[7:0];
      o.last  = 1'b0;
      return o;
   endfunction

   // Window shift, line store update and the center / border results of one pixel.
   task automatic convolve_pixel(input pixel_type px);
      int unsigned   h, w, r, c;
      pixel_type     lo, ctr;
      out_pixel_type due [$];
      h = clip_dim(cfg_height, MAX_HEIGHT);
      w = clip_dim(cfg_width, MAX_WIDTH);
      r = row_pos;
      c = col_pos;
      if (r >= h || c >= w) begin
         r = 0;
         c = 0;
      end
      lo = lower_line[c];
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = upper_line[c];
      win[1][2] = lo;
      win[2][2] = px;
      upper_line[c] = lo;
      lower_line[c] = px;
      if (r >= 2 && c >= 2) begin
         ctr = win[1][1];
         if (r - 1 >= cfg_row_lo && r - 1 < cfg_row_hi &&
             c - 1 >= cfg_col_lo && c - 1 < cfg_col_hi)
            ctr = {filtered_channel(16), filtered_channel(8), filtered_channel(0)};
         due.push_back(as_result(r - 1, c - 1, ctr));
      end
      if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
         due.push_back(as_result(r, c, px));
      if (due.size() > 0) due[due.size() - 1].last = 1'b1;
      foreach (due[i]) out_pixels_due.push_back(due[i]);
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [CH_W-1:0] pick_level();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return CH_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      int unsigned roll;
      roll = $urandom_range(19);
      if (roll == 0) return '0;
      if (roll == 1) return DIM_W'(1);
      if (roll == 2) return DIM_W'(2);
      return DIM_W'($urandom_range(10, 3));
   endfunction

   // pixel side: accept bookkeeping at the rising edge, drive at the falling edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         convolve_pixel({req_red, req_green, req_blue});
         pix_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         pix_offered = 1'b0;
         pix_gap = 0;
      end else begin
         if (pix_taken) begin
            pix_taken = 1'b0;
            pix_offered = 1'b0;
         end
         if (!pix_offered) begin
            if (pix_gap > 0) pix_gap--;
            else if (pixels_to_send.size() > 0) begin
               {req_red, req_green, req_blue} <= pixels_to_send.pop_front();
               pix_offered = 1'b1;
               pix_gap = feed_gaps_on ? pick_gap() : 0;
            end
         end
      end
      req_valid <= pix_offered;
   end

   // result side: ready pattern with a long hold on request
   always @(negedge clock) begin
      if (reset) begin
         sink_hold = 0;
         sink_stall = 0;
      end else begin
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            sink_hold = HOLD_CYCLES;
         end
         if (sink_hold > 0) sink_hold--;
         else if (sink_stall > 0) sink_stall--;
         else if (drain_stalls_on && $urandom_range(3) == 0) sink_stall = pick_gap();
      end
      rsp_ready <= !reset && sink_hold == 0 && sink_stall == 0;
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (out_pixels_due.size() == 0) begin
            $error("unexpected result item at row %0d col %0d", rsp_out_row, rsp_out_col);
            mismatch_count++;
         end else begin
            seen_due = out_pixels_due.pop_front();
            check_field("out_row", seen_due.row, rsp_out_row);
            check_field("out_col", seen_due.col, rsp_out_col);
            check_field("out_red", seen_due.red, rsp_out_red);
            check_field("out_green", seen_due.green, rsp_out_green);
            check_field("out_blue", seen_due.blue, rsp_out_blue);
            check_field("last_of_run", seen_due.last, rsp_last_of_run);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [DIM_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FILTER_MODE:   cfg_mode = data[2:0];
         CSR_IMAGE_HEIGHT:  cfg_height = data;
         CSR_IMAGE_WIDTH:   cfg_width = data;
         CSR_SEL_ROW_START: cfg_row_lo = data;
         CSR_SEL_ROW_END:   cfg_row_hi = data;
         CSR_SEL_COL_START: cfg_col_lo = data;
         CSR_SEL_COL_END:   cfg_col_hi = data;
         default:           ;
      endcase
   endtask

   task automatic close_writes();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_setup(input logic [DIM_W-1:0] mode_word, h, w, rs, re, cs, ce);
      write_reg(CSR_FILTER_MODE, mode_word);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_SEL_ROW_START, rs);
      write_reg(CSR_SEL_ROW_END, re);
      write_reg(CSR_SEL_COL_START, cs);
      write_reg(CSR_SEL_COL_END, ce);
      if ($urandom_range(3) == 0) write_reg(CSR_SPARE, DIM_W'($urandom_range(2047)));
      close_writes();
   endtask

   task automatic push_random(int unsigned n);
      repeat (n) pixels_to_send.push_back({pick_level(), pick_level(), pick_level()});
      pixels_queued += n;
   endtask

   task automatic wait_drained();
      while (pixels_to_send.size() != 0 || pix_offered || out_pixels_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned      phase, h, w, start_count, small_sent, n_img;
      logic [DIM_W-1:0] dh, dw, mode_word, rs, re, cs, ce;
      bit               big;
      small_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // saturating edge kernel: red clamps high, green clamps low
      write_setup(DIM_W'(MODE_EDGE), 3, 3, 0, DIM_TOP, 0, DIM_TOP);
      for (int k = 0; k < 9; k++)
         pixels_to_send.push_back((k == 4) ? {8'd255, 8'd0, 8'd100} : {8'd0, 8'd255, 8'd90});
      wait_drained();
      // center outside the selection passes through, then a zero-size image as 1x1
      write_setup(DIM_W'(MODE_GAUSS), 3, 3, 2, 3, 0, DIM_TOP);
      push_random(9);
      wait_drained();
      write_setup(DIM_W'(MODE_SPARE), 0, 0, 0, DIM_TOP, 0, DIM_TOP);
      pixels_to_send.push_back('1);
      wait_drained();

      for (phase = 0; small_sent < SMALL_ITEMS; phase++) begin
         feed_gaps_on = (phase != 0) && ($urandom_range(3) != 0);
         drain_stalls_on = (phase != 0) && ($urandom_range(3) != 0);
         big = (phase == 3 || phase == 6);
         if (phase == 3) begin
            dh = DIM_W'(3);
            dw = DIM_TOP;
         end else if (phase == 6) begin
            dh = DIM_W'(1030);
            dw = DIM_W'(1);
         end else if (phase == 1) begin
            dh = DIM_W'(8);
            dw = DIM_W'(10);
         end else begin
            dh = pick_dim();
            dw = pick_dim();
         end
         h = clip_dim(dh, MAX_HEIGHT);
         w = clip_dim(dw, MAX_WIDTH);
         mode_word = DIM_W'(phase % 8);
         if ($urandom_range(3) == 0) mode_word[DIM_W-1:3] = (DIM_W-3)'($urandom_range(255));
         if ($urandom_range(2) == 0) begin
            rs = '0;
            re = DIM_TOP;
            cs = '0;
            ce = DIM_TOP;
         end else begin
            rs = DIM_W'($urandom_range(h));
            re = DIM_W'($urandom_range(h + 1));
            cs = DIM_W'($urandom_range(w));
            ce = DIM_W'($urandom_range(w + 1));
         end
         write_setup(mode_word, dh, dw, rs, re, cs, ce);
         start_count = pixels_queued;
         if (phase == 1) sink_hold_request = 1'b1;

         // height shrinks under the row counter: the next pixel restarts the image
         if (!big && phase % 5 == 2 && h >= 4) begin
            push_random(3 * w + 1);
            wait_drained();
            write_reg(CSR_IMAGE_HEIGHT, DIM_W'(2));
            close_writes();
            h = 2;
         end

         n_img = big ? 1 : $urandom_range(3, 1);
         for (int i = 0; i < n_img; i++) begin
            if (i == 0 && phase % 4 == 1) begin
               push_random(h * w / 2);
               wait_drained();
               push_random(h * w - h * w / 2);
            end else
               push_random(h * w);
         end
         wait_drained();
         if (!big) small_sent += pixels_queued - start_count;
      end

      wait_drained();
      if (mismatch_count == 0 && out_pixels_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
sv/rgbk_pkg.sv
sv/rgbk_ram.sv
sv/rgbk_position.sv
sv/rgbk_tap_sum.sv
sv/rgbk_scale_clamp.sv
sv/rgbk_emit.sv
sv/rgb_3x3_kernel_filter_unit.sv
sv/rgbk_checker.sv
dv/tb_rgb_3x3_kernel_filter_unit.sv
